/* rtl/core/iidl_pkg.sv */
// ----------------------------------------------------------------------------
// iidl_pkg
// Shared types and constants of the indexed insert/delete list.
// ----------------------------------------------------------------------------
package iidl_pkg;

   localparam int LIST_DEPTH  = 128;
   localparam int GROUP_CELLS = 16;
   localparam int POS_W       = 8;
   localparam int COUNT_OUT_W = 8;
   localparam int FIELD_W     = 32;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_WRITE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] size;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '1;

   typedef struct packed {
      logic             load;
      logic             insert;
      logic             delete;
      logic             write;
      logic [POS_W-1:0] position;
      entry_type        data;
   } cell_cmd_type;

endpackage

/* rtl/core/indexed_insert_delete_list.sv */
// ----------------------------------------------------------------------------
// indexed_insert_delete_list
// Ordered list of offset/size entries with positional insert, delete,
// read and write, kept in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel  direction  ports
//  req      in         req_valid req_ready req_mode req_position
//                      req_entry_offset req_entry_size
//  rsp      out        rsp_valid rsp_ready rsp_read_offset rsp_read_size
//                      rsp_entry_count rsp_status
//
//  Every cell updates in the cycle the request is accepted, so one request
//  is taken per cycle while no response stall holds req_ready low. The
//  readout passes one registered group stage and then the response register.
//  Reset fills every slot with all ones and clears the count. A stalled
//  response holds one request in the group stage; req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list import iidl_pkg::*; #(
   parameter int DEPTH = LIST_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   input  logic [POS_W-1:0]       req_position,
   input  logic [FIELD_W-1:0]     req_entry_offset,
   input  logic [FIELD_W-1:0]     req_entry_size,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FIELD_W-1:0]     rsp_read_offset,
   output logic [FIELD_W-1:0]     rsp_read_size,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [1:0]             rsp_status
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(DEPTH);

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   stage_valid_ff;
   status_type             stage_status_ff;
   logic [COUNT_OUT_W-1:0] stage_count_ff;
   logic                   stage_return_ff;
   logic                   rsp_valid_ff;
   logic [FIELD_W-1:0]     rsp_offset_ff;
   logic [FIELD_W-1:0]     rsp_size_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   status_type             rsp_status_ff;

   logic             accept;
   logic             advance;
   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic [CMP_W-1:0] cnt_next_w;
   mode_type         mode;
   status_type       status;
   logic             ok;
   cell_cmd_type     cmd;
   entry_type        read_entry;

   assign mode    = mode_type'(req_mode);
   assign pos_w   = CMP_W'(req_position);
   assign cnt_w   = CMP_W'(count_ff);
   assign advance = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign accept  = req_valid && req_ready;

   always_comb begin
      status = STATUS_DONE;
      if (mode == MODE_INSERT) begin
         if (cnt_w == DEPTH_W) begin
            status = STATUS_FULL;
         end else if (pos_w > cnt_w) begin
            status = STATUS_RANGE;
         end
      end else if (pos_w >= cnt_w) begin
         status = STATUS_RANGE;
      end
   end

   assign ok = accept && (status == STATUS_DONE);

   always_comb begin
      cmd.load     = accept;
      cmd.insert   = ok && (mode == MODE_INSERT);
      cmd.delete   = ok && (mode == MODE_DELETE);
      cmd.write    = ok && (mode == MODE_WRITE);
      cmd.position = req_position;
      cmd.data     = '{offset: req_entry_offset, size: req_entry_size};
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.delete) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign cnt_next_w = CMP_W'(count_in);

   iidl_row #(
      .DEPTH (DEPTH),
      .CMP_W (CMP_W)
   ) u_row (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .read_entry (read_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_status_ff <= status;
         stage_count_ff  <= cnt_next_w[COUNT_OUT_W-1:0];
         stage_return_ff <= ok && ((mode == MODE_DELETE) || (mode == MODE_READ));
      end
      if (advance) begin
         rsp_offset_ff <= stage_return_ff ? read_entry.offset : '0;
         rsp_size_ff   <= stage_return_ff ? read_entry.size : '0;
         rsp_count_ff  <= stage_count_ff;
         rsp_status_ff <= stage_status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_offset = rsp_offset_ff;
   assign rsp_read_size   = rsp_size_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= DEPTH_W)
      else $error("count exceeds depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (mode == MODE_INSERT) && (status == STATUS_DONE))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the list");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_DONE))
      |-> ((rsp_read_offset == '0) && (rsp_read_size == '0)))
      else $error("failed request returned data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL))
      |-> (rsp_entry_count == DEPTH_W[COUNT_OUT_W-1:0]))
      else $error("full status with short list");

endmodule

/* rtl/core/iidl_cell.sv */
// ----------------------------------------------------------------------------
// iidl_cell
// One list slot: holds, loads, or takes the entry of a neighbor.
// ----------------------------------------------------------------------------
module iidl_cell import iidl_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CMP_W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   output entry_type    entry,
   output entry_type    hit_entry
);

   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   entry_type        entry_ff;
   entry_type        entry_in;
   logic [CMP_W-1:0] pos;

   assign pos = CMP_W'(cmd.position);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (IDX > pos) begin
            entry_in = left_entry;
         end else if (IDX == pos) begin
            entry_in = cmd.data;
         end
      end else if (cmd.delete) begin
         if (IDX >= pos) begin
            entry_in = right_entry;
         end
      end else if (cmd.write && (IDX == pos)) begin
         entry_in = cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= EMPTY_ENTRY;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry     = entry_ff;
   assign hit_entry = (IDX == pos) ? entry_ff : '0;

endmodule

/* rtl/core/iidl_row.sv */
// ----------------------------------------------------------------------------
// iidl_row
// Row of list cells with a registered readout tree over cell groups.
// ----------------------------------------------------------------------------
module iidl_row import iidl_pkg::*; #(
   parameter int DEPTH = LIST_DEPTH,
   parameter int CMP_W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   output entry_type    read_entry
);

   localparam int NUM_GROUPS = (DEPTH + GROUP_CELLS - 1) / GROUP_CELLS;
   localparam int PAD_DEPTH  = NUM_GROUPS * GROUP_CELLS;

   entry_type cell_entry [DEPTH];
   entry_type hit_entry  [PAD_DEPTH];
   entry_type group_ff   [NUM_GROUPS];
   entry_type group_in   [NUM_GROUPS];

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;

      if (k == 0) begin : g_first
         assign left_entry = EMPTY_ENTRY;
      end else begin : g_left
         assign left_entry = cell_entry[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign right_entry = EMPTY_ENTRY;
      end else begin : g_right
         assign right_entry = cell_entry[k+1];
      end

      iidl_cell #(
         .INDEX (k),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[k]),
         .hit_entry   (hit_entry[k])
      );
   end

   for (genvar k = DEPTH; k < PAD_DEPTH; k++) begin : g_pad
      assign hit_entry[k] = '0;
   end

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP_CELLS; j++) begin
            group_in[g] = group_in[g] | hit_entry[g*GROUP_CELLS + j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_ff[g] <= group_in[g];
         end
      end
   end

   always_comb begin
      read_entry = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         read_entry = read_entry | group_ff[g];
      end
   end

endmodule

/* tb/indexed_insert_delete_list_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_tb
// Self-checking bench for the indexed insert/delete list. Requests run
// through a valid/ready driver, and a shadow list predicts each response
// when its request is taken. A monitor compares every response field with
// the oldest prediction. Stimulus starts with a directed sweep of the edge
// cases. Random phases follow that grow the list, shrink it and mix both,
// with random gaps on both channels and one long response stall.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_tb;
   import iidl_pkg::*;

   localparam int RANDOM_REQUESTS = 1500;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_CYCLES     = 300;
   localparam int HOLD_AT         = 400;
   localparam int QUIET_LO        = 700;
   localparam int QUIET_HI        = 1000;
   localparam int DRAIN_CYCLES    = 10;

   typedef struct {
      mode_type         mode;
      logic [POS_W-1:0] position;
      entry_type        entry;
   } list_req_type;

   typedef struct {
      logic [FIELD_W-1:0]     offset;
      logic [FIELD_W-1:0]     size;
      logic [COUNT_OUT_W-1:0] count;
      status_type             status;
   } list_rsp_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   mode_type               req_mode  = MODE_READ;
   logic [POS_W-1:0]       req_position     = '0;
   logic [FIELD_W-1:0]     req_entry_offset = '0;
   logic [FIELD_W-1:0]     req_entry_size   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [FIELD_W-1:0]     rsp_read_offset;
   logic [FIELD_W-1:0]     rsp_read_size;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic [1:0]             rsp_status;

   list_req_type pending_req[$];
   list_rsp_type expected_rsp[$];
   entry_type    shadow_slots[LIST_DEPTH];
   int           shadow_count;
   int           planned_fill;
   int           sent_total;
   int           rsp_total;
   int           fail_count;
   int           stall_cycles;
   int           hold_left;
   bit           hold_done;

   indexed_insert_delete_list DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_position     (req_position),
      .req_entry_offset (req_entry_offset),
      .req_entry_size   (req_entry_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_offset  (rsp_read_offset),
      .rsp_read_size    (rsp_read_size),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_status       (rsp_status)
   );

   always #5 clock = ~clock;

   // shadow list: apply one request and return its response
   task automatic apply_list_op(input list_req_type rq, output list_rsp_type rs);
      int p;
      int k;
      p         = rq.position;
      rs.offset = '0;
      rs.size   = '0;
      rs.status = STATUS_DONE;
      if (rq.mode == MODE_INSERT) begin
         if (shadow_count >= LIST_DEPTH) begin
            rs.status = STATUS_FULL;
         end else if (p > shadow_count) begin
            rs.status = STATUS_RANGE;
         end else begin
            for (k = shadow_count; k > p; k--)
               shadow_slots[k] = shadow_slots[k-1];
            shadow_slots[p] = rq.entry;
            shadow_count++;
         end
      end else if (p >= shadow_count) begin
         rs.status = STATUS_RANGE;
      end else begin
         case (rq.mode)
            MODE_DELETE: begin
               rs.offset = shadow_slots[p].offset;
               rs.size   = shadow_slots[p].size;
               for (k = p; k + 1 < shadow_count; k++)
                  shadow_slots[k] = shadow_slots[k+1];
               shadow_slots[shadow_count-1] = EMPTY_ENTRY;
               shadow_count--;
            end
            MODE_READ: begin
               rs.offset = shadow_slots[p].offset;
               rs.size   = shadow_slots[p].size;
            end
            default: begin
               shadow_slots[p] = rq.entry;
            end
         endcase
      end
      rs.count = COUNT_OUT_W'(shadow_count);
   endtask

   // queue a request and track the fill it leads to
   task automatic queue_request(input mode_type m, input int pos,
                                input logic [FIELD_W-1:0] off,
                                input logic [FIELD_W-1:0] sz);
      list_req_type rq;
      rq.mode         = m;
      rq.position     = POS_W'(pos);
      rq.entry.offset = off;
      rq.entry.size   = sz;
      pending_req.push_back(rq);
      if (m == MODE_INSERT) begin
         if (planned_fill < LIST_DEPTH && pos <= planned_fill) planned_fill++;
      end else if (pos < planned_fill) begin
         planned_fill--;
      end
   endtask

   function automatic int pick_position(input bit for_insert);
      int span;
      span = for_insert ? planned_fill + 1 : planned_fill;
      if (span > 0 && $urandom_range(99) < 88) begin
         case ($urandom_range(9))
            0:       return 0;
            1:       return span - 1;
            default: return $urandom_range(span - 1);
         endcase
      end
      return $urandom_range(255);
   endfunction

   function automatic logic [FIELD_W-1:0] pick_field();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      list_req_type nxt;
      logic         idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         idle = (sent_total < QUIET_LO || sent_total >= QUIET_HI) &&
                ($urandom_range(99) < 23);
         if (pending_req.size() != 0 && !idle) begin
            nxt = pending_req.pop_front();
            req_valid        <= 1'b1;
            req_mode         <= nxt.mode;
            req_position     <= nxt.position;
            req_entry_offset <= nxt.entry.offset;
            req_entry_size   <= nxt.entry.size;
            sent_total       <= sent_total + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_total >= HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (rsp_total >= QUIET_LO && rsp_total < QUIET_HI) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 23);
      end
   end

   // predict on request, check on response
   always @(posedge clock) begin
      list_req_type rq;
      list_rsp_type rs;
      list_rsp_type want;
      if (reset) begin
         for (int k = 0; k < LIST_DEPTH; k++) shadow_slots[k] = EMPTY_ENTRY;
         shadow_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            rq.mode         = req_mode;
            rq.position     = req_position;
            rq.entry.offset = req_entry_offset;
            rq.entry.size   = req_entry_size;
            apply_list_op(rq, rs);
            expected_rsp.push_back(rs);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_total <= rsp_total + 1;
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response offset=%h size=%h count=%0d status=%0d",
                        $time, rsp_read_offset, rsp_read_size, rsp_entry_count,
                        rsp_status);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_read_offset !== want.offset) begin
                  $display("%0t: read_offset expected %h actual %h",
                           $time, want.offset, rsp_read_offset);
                  fail_count++;
               end
               if (rsp_read_size !== want.size) begin
                  $display("%0t: read_size expected %h actual %h",
                           $time, want.size, rsp_read_size);
                  fail_count++;
               end
               if (rsp_entry_count !== want.count) begin
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, want.count, rsp_entry_count);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int phase;
      int pick;
      mode_type m;

      planned_fill = 0;
      queue_request(MODE_READ,   0,   '0, '0);
      queue_request(MODE_DELETE, 0,   '0, '0);
      queue_request(MODE_WRITE,  0,   '1, '1);
      queue_request(MODE_INSERT, 1,   32'h1111_1111, 32'h2222_2222);
      queue_request(MODE_INSERT, 0,   '1, '1);
      queue_request(MODE_INSERT, 0,   '0, '0);
      queue_request(MODE_INSERT, 2,   32'hA5A5_A5A5, 32'h5A5A_5A5A);
      queue_request(MODE_INSERT, 1,   32'h8000_0001, 32'h7FFF_FFFE);
      queue_request(MODE_READ,   0,   '0, '0);
      queue_request(MODE_READ,   3,   '0, '0);
      queue_request(MODE_READ,   4,   '0, '0);
      queue_request(MODE_WRITE,  3,   32'hDEAD_0123, 32'h0BAD_CAFE);
      queue_request(MODE_WRITE,  4,   32'h1234_5678, 32'h9ABC_DEF0);
      queue_request(MODE_READ,   3,   '0, '0);
      queue_request(MODE_DELETE, 1,   '1, '1);
      queue_request(MODE_DELETE, 2,   '0, '0);
      queue_request(MODE_DELETE, 0,   '0, '0);
      queue_request(MODE_INSERT, 255, '1, '1);
      queue_request(MODE_INSERT, 128, '0, '0);
      queue_request(MODE_READ,   255, '0, '0);
      queue_request(MODE_DELETE, 200, '0, '0);
      queue_request(MODE_WRITE,  128, '1, '1);
      queue_request(MODE_READ,   1,   '0, '0);
      queue_request(MODE_READ,   0,   '0, '0);

      // alternate grow, shrink and mixed phases
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         phase = (i / 250) % 3;
         pick  = $urandom_range(99);
         case (phase)
            0:       m = (pick < 60) ? MODE_INSERT : (pick < 70) ? MODE_DELETE :
                         (pick < 85) ? MODE_READ : MODE_WRITE;
            1:       m = (pick < 10) ? MODE_INSERT : (pick < 65) ? MODE_DELETE :
                         (pick < 85) ? MODE_READ : MODE_WRITE;
            default: m = (pick < 30) ? MODE_INSERT : (pick < 55) ? MODE_DELETE :
                         (pick < 80) ? MODE_READ : MODE_WRITE;
         endcase
         queue_request(m, pick_position(m == MODE_INSERT), pick_field(), pick_field());
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
